>>> hw/rtl/wmme_pkg.sv
package wmme_pkg;
    localparam int unsigned SampleWidth = 32;
    localparam int unsigned SpbWidth    = 24;
    localparam int unsigned BinWidth    = 16;

    typedef enum logic [0:0] {
        CFG_SAMPLES_PER_BIN = 1'b0,
        CFG_BIN_COUNT       = 1'b1
    } t_cfg_index;

    localparam logic [SampleWidth-1:0] FloatZero = '0;

    function automatic logic f_is_finite(input logic [SampleWidth-1:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    function automatic logic [SampleWidth-1:0] f_order_key(input logic [SampleWidth-1:0] b);
        logic [SampleWidth-1:0] v;
        v = (b == 32'h8000_0000) ? '0 : b;
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction
endpackage

>>> hw/rtl/waveform_min_max_envelope.sv
// Min/max envelope decimator for float32 sample streams. One sample is taken
// per clock; each bin of samples_per_bin samples yields one result of min, max
// (0.0 if no finite sample) and bin index, in the cycle after its last sample. NaN
// and infinities are skipped but counted. After bin_count bins further samples
// are accepted and dropped until reset. Rate is set by the combinational float
// compare: one sample per cycle, as long as the result register drains.
module waveform_min_max_envelope
    import wmme_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SampleWidth-1:0] i_sample_bits,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SampleWidth-1:0] o_bin_min,
    output logic [SampleWidth-1:0] o_bin_max,
    output logic [BinWidth-1:0]    o_bin_index,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [0:0]             i_cfg_index,
    input  logic [SpbWidth-1:0]    i_cfg_data
);
    logic [SpbWidth-1:0]    r_spb;
    logic [BinWidth-1:0]    r_bins;
    logic [SampleWidth-1:0] r_low, r_high, n_low, n_high;
    logic                   r_any, n_any;
    logic [SpbWidth-1:0]    r_fill, n_fill;
    logic [BinWidth-1:0]    r_bin;
    logic                   r_done;
    logic                   r_ovalid;
    logic [SampleWidth-1:0] r_omin, r_omax;
    logic [BinWidth-1:0]    r_oidx;
    logic                   w_acc, w_close;
    logic [SpbWidth-1:0]    w_need;
    logic [BinWidth-1:0]    w_nbins, w_bin1;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_ovalid || i_ready;
    assign w_acc       = i_valid && o_ready;
    assign w_need      = (r_spb == '0) ? SpbWidth'(1) : r_spb;
    assign w_nbins     = (r_bins == '0) ? BinWidth'(1) : r_bins;
    assign n_fill      = r_fill + SpbWidth'(1);
    assign w_close     = n_fill >= w_need;
    assign w_bin1      = r_bin + BinWidth'(1);

    wmme_extreme u_ext (
        .i_sample(i_sample_bits), .i_any(r_any), .i_low(r_low), .i_high(r_high),
        .o_any(n_any), .o_low(n_low), .o_high(n_high)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb <= SpbWidth'(1);
            r_bins <= BinWidth'(1);
            r_any <= 1'b0; r_fill <= '0; r_bin <= '0; r_done <= 1'b0;
            r_ovalid <= 1'b0;
            r_low <= FloatZero; r_high <= FloatZero;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SAMPLES_PER_BIN: r_spb <= i_cfg_data;
                    CFG_BIN_COUNT:       r_bins <= i_cfg_data[BinWidth-1:0];
                    default: ;
                endcase
            end
            if (w_acc && !r_done && w_close) r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            if (w_acc && !r_done) begin
                if (w_close) begin
                    r_omin <= n_any ? n_low : FloatZero;
                    r_omax <= n_any ? n_high : FloatZero;
                    r_oidx <= r_bin;
                    r_any <= 1'b0; r_low <= FloatZero; r_high <= FloatZero;
                    r_fill <= '0;
                    r_bin <= w_bin1;
                    if (w_bin1 >= w_nbins || w_bin1 == '0) r_done <= 1'b1;
                end else begin
                    r_any <= n_any; r_low <= n_low; r_high <= n_high;
                    r_fill <= n_fill;
                end
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_bin_min   = r_omin;
    assign o_bin_max   = r_omax;
    assign o_bin_index = r_oidx;
endmodule

>>> hw/rtl/wmme_extreme.sv
module wmme_extreme
    import wmme_pkg::*;
(
    input  logic [SampleWidth-1:0] i_sample,
    input  logic                   i_any,
    input  logic [SampleWidth-1:0] i_low,
    input  logic [SampleWidth-1:0] i_high,
    output logic                   o_any,
    output logic [SampleWidth-1:0] o_low,
    output logic [SampleWidth-1:0] o_high
);
    logic                   w_fin;
    logic [SampleWidth-1:0] w_k;

    assign w_fin = f_is_finite(i_sample);
    assign w_k   = f_order_key(i_sample);

    always_comb begin
        o_any  = i_any | w_fin;
        o_low  = i_low;
        o_high = i_high;
        if (w_fin) begin
            if (!i_any) begin
                o_low  = i_sample;
                o_high = i_sample;
            end else begin
                if (w_k < f_order_key(i_low))  o_low  = i_sample;
                if (w_k > f_order_key(i_high)) o_high = i_sample;
            end
        end
    end
endmodule

>>> hw/rtl/wmme_checker.sv
module wmme_checker
    import wmme_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic                   o_ready,
    input logic [SampleWidth-1:0] o_bin_min,
    input logic [SampleWidth-1:0] o_bin_max,
    input logic [BinWidth-1:0]    o_bin_index
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bin_index) && $stable(o_bin_min))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("not ready with empty output");
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bin_min[30:23] != 8'hFF && o_bin_max[30:23] != 8'hFF)
        else $error("non-finite extreme");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind waveform_min_max_envelope wmme_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_ready(o_ready), .o_bin_min(o_bin_min), .o_bin_max(o_bin_max),
    .o_bin_index(o_bin_index)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import wmme_pkg::*;

    localparam int unsigned CycleLimit = 2_000_000;
    localparam int unsigned RandomItems = 1700;

    typedef struct packed {
        logic [SampleWidth-1:0] bin_min;
        logic [SampleWidth-1:0] bin_max;
        logic [BinWidth-1:0]    bin_index;
    } t_envelope;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [SampleWidth-1:0] i_sample_bits;
    logic                   o_valid;
    logic                   i_ready;
    logic [SampleWidth-1:0] o_bin_min;
    logic [SampleWidth-1:0] o_bin_max;
    logic [BinWidth-1:0]    o_bin_index;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [0:0]             i_cfg_index;
    logic [SpbWidth-1:0]    i_cfg_data;

    waveform_min_max_envelope dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_bits (i_sample_bits),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_bin_min     (o_bin_min),
        .o_bin_max     (o_bin_max),
        .o_bin_index   (o_bin_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [SpbWidth-1:0]    spb;
    logic [BinWidth-1:0]    nbins;
    logic [SampleWidth-1:0] low_val;
    logic [SampleWidth-1:0] high_val;
    logic                   seen_finite;
    logic [SpbWidth-1:0]    fill;
    logic [BinWidth-1:0]    bin_num;
    logic                   finished;

    t_envelope   envelope_q[$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned sink_wait;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [31:0] fkey(input logic [31:0] b);
        logic [31:0] v;
        v = (b == 32'h8000_0000) ? 32'h0 : b;
        return v[31] ? ~v : {1'b1, v[30:0]};
    endfunction

    task automatic predict_bin(input logic [31:0] s);
        logic [23:0] need;
        logic [15:0] lim;
        t_envelope   e;
        need = (spb == 0) ? 24'd1 : spb;
        lim  = (nbins == 0) ? 16'd1 : nbins;
        if (finished) return;
        if (s[30:23] != 8'hFF) begin
            if (!seen_finite) begin
                low_val = s;
                high_val = s;
                seen_finite = 1'b1;
            end else begin
                if (fkey(s) < fkey(low_val)) low_val = s;
                if (fkey(s) > fkey(high_val)) high_val = s;
            end
        end
        fill = fill + 1'b1;
        if (fill < need) return;
        e.bin_min = seen_finite ? low_val : FloatZero;
        e.bin_max = seen_finite ? high_val : FloatZero;
        e.bin_index = bin_num;
        envelope_q.push_back(e);
        low_val = '0;
        high_val = '0;
        seen_finite = 1'b0;
        fill = '0;
        bin_num = bin_num + 1'b1;
        if (bin_num >= lim || bin_num == 0) finished = 1'b1;
    endtask

    task automatic idle_cycles(input int unsigned n);
        repeat (n) @(posedge i_clk);
    endtask

    // valid stays up between back-to-back transactions; it drops only for a gap
    task automatic send_sample(input logic [31:0] s);
        int unsigned gap;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_valid <= 1'b0;
            idle_cycles(gap);
        end
        i_valid <= 1'b1;
        i_sample_bits <= s;
        do @(posedge i_clk); while (!o_ready);
        predict_bin(s);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_SAMPLES_PER_BIN) spb = data;
        else nbins = data[15:0];
    endtask

    // drain, then restart bin tracking via a fresh reset is not allowed, so
    // phases only reconfigure while the block still has bins left to emit
    task automatic drain;
        i_valid <= 1'b0;
        while (envelope_q.size() != 0) @(posedge i_clk);
        idle_cycles(4);
    endtask

    function automatic logic [31:0] rand_float;
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'hFF;
            1: v[30:23] = 8'h00;
            2: v = {v[31], 31'h0};
            3: v[30:23] = 8'h7F;
            4: v[30:0] = {8'h7F, v[22:20], 20'h0};
            default: ;
        endcase
        return v;
    endfunction

    // sink: random stall per transaction, compare against oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (envelope_q.size() == 0) begin
                    report("unexpected", {16'h0, o_bin_index}, 32'h0);
                end else begin
                    if (o_bin_min !== envelope_q[0].bin_min)
                        report("bin_min", o_bin_min, envelope_q[0].bin_min);
                    if (o_bin_max !== envelope_q[0].bin_max)
                        report("bin_max", o_bin_max, envelope_q[0].bin_max);
                    if (o_bin_index !== envelope_q[0].bin_index)
                        report("bin_index", {16'h0, o_bin_index}, {16'h0, envelope_q[0].bin_index});
                    void'(envelope_q.pop_front());
                end
            end
            if (sink_wait != 0) begin
                sink_wait <= sink_wait - 1;
                i_ready <= 1'b0;
            end else if (o_valid && i_ready) begin
                if ($urandom_range(0, 2) == 0) begin
                    sink_wait <= $urandom_range(1, 13);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end else begin
                i_ready <= 1'b1;
            end
        end
        if (cycles > CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // directed samples: bin_count large, spb 1 so each row is one bin
    typedef struct {
        logic [31:0] s;
        logic        typed;
        logic [31:0] mn;
    } t_row;

    t_row rows[] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h8000_0000, 1'b1, 32'h8000_0000},
        '{32'h7F80_0000, 1'b1, 32'h0000_0000},
        '{32'hFF80_0000, 1'b1, 32'h0000_0000},
        '{32'h7FC0_0001, 1'b1, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        '{32'h7F7F_FFFF, 1'b1, 32'h7F7F_FFFF},
        '{32'hFF7F_FFFF, 1'b1, 32'hFF7F_FFFF},
        '{32'h0000_0001, 1'b1, 32'h0000_0001},
        '{32'h8000_0001, 1'b1, 32'h8000_0001},
        '{32'h3F80_0000, 1'b0, 32'h0},
        '{32'hBF80_0000, 1'b0, 32'h0}
    };

    // bins of 3: zero sign kept, nan skipped, subnormal order
    logic [31:0] triples[] = '{
        32'h8000_0000, 32'h0000_0000, 32'h7FC0_0000,
        32'h7F80_0000, 32'h0000_0000, 32'h8000_0000,
        32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF,
        32'h3F80_0000, 32'hFF80_0000, 32'h4000_0000
    };

    initial begin
        int unsigned phase;
        int unsigned k;
        int unsigned total;
        errors = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample_bits = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SAMPLES_PER_BIN;
        i_cfg_data = '0;
        spb = 24'd1;
        nbins = 16'd1;
        low_val = '0;
        high_val = '0;
        seen_finite = 1'b0;
        fill = '0;
        bin_num = '0;
        finished = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(CFG_SAMPLES_PER_BIN, 24'd1);
        write_reg(CFG_BIN_COUNT, 24'hFFFF);
        foreach (rows[i]) begin
            if (rows[i].typed && envelope_q.size() == 0) begin
                send_sample(rows[i].s);
                if (envelope_q[$].bin_min !== rows[i].mn)
                    report("directed", envelope_q[$].bin_min, rows[i].mn);
            end else begin
                send_sample(rows[i].s);
            end
            drain();
        end
        write_reg(CFG_SAMPLES_PER_BIN, 24'd3);
        foreach (triples[i]) send_sample(triples[i]);
        drain();
        // zero spb behaves as one
        write_reg(CFG_SAMPLES_PER_BIN, 24'd0);
        send_sample(32'h4120_0000);
        drain();
        // largest spb: a few samples, partial bin only; then shrink to close it
        write_reg(CFG_SAMPLES_PER_BIN, 24'hFF_FFFF);
        for (k = 0; k < 5; k++) send_sample(rand_float());
        drain();
        write_reg(CFG_SAMPLES_PER_BIN, 24'd2);
        send_sample(rand_float());
        drain();

        // random phases with varying bin sizes, bin count still open
        total = 0;
        phase = 0;
        while (total < RandomItems - 200) begin
            write_reg(CFG_SAMPLES_PER_BIN, 24'($urandom_range(1, (phase % 4 == 0) ? 40 : 6)));
            for (k = 0; k < 150; k++) send_sample(rand_float());
            total += 150;
            phase++;
            drain();
        end
        // finish: cap bin count just past current, including zero-as-one case
        write_reg(CFG_SAMPLES_PER_BIN, 24'd4);
        write_reg(CFG_BIN_COUNT, 24'(bin_num + 3));
        for (k = 0; k < 40; k++) send_sample(rand_float());
        drain();
        write_reg(CFG_BIN_COUNT, 24'd0);
        for (k = 0; k < 10; k++) send_sample(rand_float());
        drain();
        idle_cycles(20);
        if (errors == 0 && envelope_q.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
